@@ sv/hysteresis_peak_detector_top_assert.svh @@
// ----------------------------------------------------------------------------
// hysteresis peak detector assertion macros
// shared concurrent assertion forms, reset-qualified on the active-low reset
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_PEAK_DETECTOR_TOP_ASSERT_SVH
`define HYSTERESIS_PEAK_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define HPD_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("hysteresis peak detector: same-cycle check failed");

// next-cycle implication
`define HPD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("hysteresis peak detector: next-cycle check failed");

`endif

@@ sv/hpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hpd_pkg
// types and constants of the hysteresis peak detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POSITION_W = 32;
    localparam int DELTA_W    = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;

    // running extremes need one bit beyond the sample range
    localparam int RUN_W = SAMPLE_W + 1;
    // compare width: holds an extreme minus or plus delta without wrap
    localparam int EXT_W = ((RUN_W > DELTA_W + 1) ? RUN_W : DELTA_W + 1) + 1;
    // window arithmetic width
    localparam int WIN_W = (POSITION_W > CFG_W) ? POSITION_W : CFG_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [POSITION_W-1:0]      position_t;
    typedef logic signed [RUN_W-1:0]    run_t;
    typedef logic signed [EXT_W-1:0]    ext_t;
    typedef logic [WIN_W-1:0]           win_t;

    typedef struct packed {
        sample_t sample;
        logic    new_series;
    } in_word_t;

    typedef struct packed {
        position_t peak_position;
        sample_t   peak_value;
        logic      peak_is_minimum;
    } out_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELTA         = 3'd0,
        CFG_WINDOW_OFFSET = 3'd1,
        CFG_WINDOW_LENGTH = 3'd2,
        CFG_OMIT_MAXIMA   = 3'd3,
        CFG_OMIT_MINIMA   = 3'd4
    } cfg_index_t;

    // one below the most negative sample, one above the most positive
    localparam run_t RUN_MAX_INIT = run_t'(-(64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam run_t RUN_MIN_INIT = run_t'(64'sd1 <<< (SAMPLE_W - 1));

endpackage

`default_nettype wire

@@ sv/hysteresis_peak_detector_top.sv @@
// ----------------------------------------------------------------------------
// hysteresis_peak_detector_top
// delta peak detector: reports maxima and minima confirmed by a hysteresis
// ----------------------------------------------------------------------------
// One signed sample per word, one word per cycle sustained unless out_stall
// holds the result. A word is held in an input register; a single pass of
// compares then updates the search state and loads the result register.
// The recurrence through the running extremes closes in that one compare
// stage, which sets the rate at one word per cycle. A result waits in its
// register while the next word is taken into the input register. The user
// writes configuration on a plain write port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hysteresis_peak_detector_top_assert.svh"

module hysteresis_peak_detector_top
    import hpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // sample words
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_word_t             in_word,
    // peak words
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_word
);

    localparam position_t POS_ALL_ONES = '1;

    // configuration registers
    logic [DELTA_W-1:0] delta_reg;
    logic [CFG_W-1:0]   window_offset_reg;
    logic [CFG_W-1:0]   window_length_reg;
    logic               omit_maxima_reg;
    logic               omit_minima_reg;

    // input stage
    logic      in_valid_reg;
    in_word_t  in_word_reg;

    // search state
    position_t position_reg,     position_next;
    run_t      running_max_reg,  running_max_next;
    run_t      running_min_reg,  running_min_next;
    position_t max_position_reg, max_position_next;
    position_t min_position_reg, min_position_next;
    logic      seeking_max_reg,  seeking_max_next;

    // result stage
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg,  out_word_next;

    logic out_free;
    logic fire;
    logic report;

    // the result register can take a new word this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg         <= '0;
            window_offset_reg <= '0;
            window_length_reg <= '1;
            omit_maxima_reg   <= 1'b0;
            omit_minima_reg   <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_DELTA:         delta_reg         <= cfg_data[DELTA_W-1:0];
                CFG_WINDOW_OFFSET: window_offset_reg <= cfg_data;
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                CFG_OMIT_MAXIMA:   omit_maxima_reg   <= cfg_data[0];
                CFG_OMIT_MINIMA:   omit_minima_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // input register: loads whenever it is empty or drains this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_word_reg <= in_word;
        end
    end

    // single compare pass over one sample
    always_comb
    begin
        position_t p;
        position_t offset_pos;
        run_t      rmax;
        run_t      rmin;
        position_t pmax;
        position_t pmin;
        logic      seek;
        ext_t      cur_ext;
        ext_t      delta_ext;
        win_t      p_w;
        win_t      off_w;
        logic      in_window;
        logic      confirm;

        position_next     = position_reg;
        running_max_next  = running_max_reg;
        running_min_next  = running_min_reg;
        max_position_next = max_position_reg;
        min_position_next = min_position_reg;
        seeking_max_next  = seeking_max_reg;
        report            = 1'b0;
        out_word_next     = out_word_reg;

        offset_pos = position_t'(window_offset_reg);
        cur_ext    = ext_t'(in_word_reg.sample);
        delta_ext  = ext_t'(delta_reg);

        // a new series restarts the count and the search first
        if (in_word_reg.new_series)
        begin
            p    = '0;
            rmax = RUN_MAX_INIT;
            rmin = RUN_MIN_INIT;
            pmax = offset_pos;
            pmin = offset_pos;
            seek = 1'b1;
        end
        else
        begin
            p    = position_reg;
            rmax = running_max_reg;
            rmin = running_min_reg;
            pmax = max_position_reg;
            pmin = min_position_reg;
            seek = seeking_max_reg;
        end

        p_w       = win_t'(p);
        off_w     = win_t'(window_offset_reg);
        in_window = (p_w >= off_w) && ((p_w - off_w) < win_t'(window_length_reg));
        confirm   = 1'b0;

        if (in_window)
        begin
            if (cur_ext > ext_t'(rmax))
            begin
                rmax = run_t'(in_word_reg.sample);
                pmax = p;
            end
            if (cur_ext < ext_t'(rmin))
            begin
                rmin = run_t'(in_word_reg.sample);
                pmin = p;
            end

            if (seek)
            begin
                // maximum confirmed: report it unless maxima are omitted, then hunt for a minimum
                if (cur_ext < ext_t'(rmax) - delta_ext)
                begin
                    confirm                       = 1'b1;
                    report                        = !omit_maxima_reg;
                    out_word_next.peak_position   = pmax;
                    out_word_next.peak_value      = sample_t'(rmax[SAMPLE_W-1:0]);
                    out_word_next.peak_is_minimum = 1'b0;
                    rmin                          = run_t'(in_word_reg.sample);
                    pmin                          = p;
                end
            end
            else
            begin
                // minimum confirmed: report it unless minima are omitted, then hunt for a maximum
                if (cur_ext > ext_t'(rmin) + delta_ext)
                begin
                    confirm                       = 1'b1;
                    report                        = !omit_minima_reg;
                    out_word_next.peak_position   = pmin;
                    out_word_next.peak_value      = sample_t'(rmin[SAMPLE_W-1:0]);
                    out_word_next.peak_is_minimum = 1'b1;
                    rmax                          = run_t'(in_word_reg.sample);
                    pmax                          = p;
                end
            end
            if (confirm)
            begin
                seek = !seek;
            end
        end

        if (fire)
        begin
            // position saturates at all ones
            position_next     = (p != POS_ALL_ONES) ? p + 1'b1 : p;
            running_max_next  = rmax;
            running_min_next  = rmin;
            max_position_next = pmax;
            min_position_next = pmin;
            seeking_max_next  = seek;
        end
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = report;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            running_max_reg  <= RUN_MAX_INIT;
            running_min_reg  <= RUN_MIN_INIT;
            max_position_reg <= '0;
            min_position_reg <= '0;
            seeking_max_reg  <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            position_reg     <= position_next;
            running_max_reg  <= running_max_next;
            running_min_reg  <= running_min_next;
            max_position_reg <= max_position_next;
            min_position_reg <= min_position_next;
            seeking_max_reg  <= seeking_max_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload loads only with a report
    always_ff @(posedge clk)
    begin
        if (fire && report)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // a held input word stays put until the result side frees up
    `HPD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall,
                     in_valid_reg && $stable(in_word_reg))

    // a taken result clears unless a new report replaces it
    `HPD_ASSERT_NEXT(a_out_drain, clk, rst_n, !fire && out_valid_reg && !out_stall,
                     !out_valid_reg)

    // after a report the search direction has turned
    `HPD_ASSERT_NEXT(a_turn, clk, rst_n, fire && report,
                     out_valid_reg && (seeking_max_reg == out_word_reg.peak_is_minimum))

    // the position count sticks at its end within a series
    `HPD_ASSERT_NEXT(a_pos_sat, clk, rst_n,
                     fire && !in_word_reg.new_series && (position_reg == POS_ALL_ONES),
                     position_reg == POS_ALL_ONES)

endmodule

`default_nettype wire
